// ===== rtl/core/lfcf_pkg.sv =====
// Shared types and constants of the lowpass feedback comb filter.
package lfcf_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_DELAY_DEF   = 2048;
   localparam int SAMPLE_BITS_DEF = 24;

   // Configuration port geometry and register field widths.
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int LEN_FIELD_W  = 12;
   localparam int COEF_W       = 16;
   localparam int FRAC_BITS    = 16;
   // Coefficient operand of the multiplier: 65536 needs 17 bits, plus a sign bit.
   localparam int COEF_OP_W    = COEF_W + 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN = 2'd2;

   // Operand selection of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_NONE       = 2'd0,
      MUL_DELAYED    = 2'd1,
      MUL_STATE_DAMP = 2'd2,
      MUL_STATE_FB   = 2'd3
   } mul_sel_type;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_CLEAR = 7'b000_0001,
      ST_IDLE  = 7'b000_0010,
      ST_MUL_A = 7'b000_0100,
      ST_MUL_B = 7'b000_1000,
      ST_STATE = 7'b001_0000,
      ST_MUL_C = 7'b010_0000,
      ST_WRITE = 7'b100_0000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        clear_wr;   // write zero at the clear address and step it
      logic        capture;    // take the input beat and read the delay entry
      mul_sel_type mul_sel;    // multiplier operands for this cycle
      logic        upd_state;  // load the new lowpass state
      logic        commit;     // write back, advance the index, load the output
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;        // last entry of the clearing pass is being written
   } status_type;

endpackage

// ===== rtl/core/lfcf_ctrl.sv =====
// Sequencer of the comb filter: clearing pass, per-sample steps and result handshake.
module lfcf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lfcf_pkg::status_type  status,
   output lfcf_pkg::cmd_type     cmd
);

   lfcf_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                accept;

   // The output register can take a beat when it is empty or being emptied.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lfcf_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd.clear_wr  = 1'b0;
      cmd.capture   = 1'b0;
      cmd.mul_sel   = lfcf_pkg::MUL_NONE;
      cmd.upd_state = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         lfcf_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) begin
               state_in = lfcf_pkg::ST_IDLE;
            end
         end
         lfcf_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = lfcf_pkg::ST_MUL_A;
            end
         end
         lfcf_pkg::ST_MUL_A: begin
            cmd.mul_sel = lfcf_pkg::MUL_DELAYED;
            state_in    = lfcf_pkg::ST_MUL_B;
         end
         lfcf_pkg::ST_MUL_B: begin
            cmd.mul_sel = lfcf_pkg::MUL_STATE_DAMP;
            state_in    = lfcf_pkg::ST_STATE;
         end
         lfcf_pkg::ST_STATE: begin
            cmd.upd_state = 1'b1;
            state_in      = lfcf_pkg::ST_MUL_C;
         end
         lfcf_pkg::ST_MUL_C: begin
            cmd.mul_sel = lfcf_pkg::MUL_STATE_FB;
            state_in    = lfcf_pkg::ST_WRITE;
         end
         lfcf_pkg::ST_WRITE: begin
            // Hold here while the previous result still waits downstream.
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = lfcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfcf_pkg::ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfcf_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/lfcf_dp.sv =====
// Datapath of the comb filter: registers, delay memory, shared multiplier and saturation.
module lfcf_dp #(
   parameter int MAX_DELAY   = lfcf_pkg::MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = lfcf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [lfcf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lfcf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample_out,
   input  lfcf_pkg::cmd_type                     cmd,
   output lfcf_pkg::status_type                  status
);

   localparam int AW    = $clog2(MAX_DELAY);
   localparam int LEN_W = AW + 1;
   localparam int CW    = lfcf_pkg::COEF_OP_W;
   localparam int FB    = lfcf_pkg::FRAC_BITS;
   localparam int PW    = SAMPLE_BITS + CW;      // product width
   localparam int SW    = PW + 1;                // width of the two-product sum
   localparam int NW    = SAMPLE_BITS + 3;       // pre-saturation width

   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Configuration registers.
   logic [LEN_W-1:0]               len_ff, len_in;
   logic [lfcf_pkg::COEF_W-1:0]    damp_ff, damp_in;
   logic [lfcf_pkg::COEF_W-1:0]    fbg_ff, fbg_in;
   logic [lfcf_pkg::LEN_FIELD_W-1:0] len_field;

   // Filter state and working registers.
   logic [AW-1:0]                  idx_ff, idx_in;
   logic [AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic signed [SAMPLE_BITS-1:0]  lp_state_ff, lp_state_in;
   logic signed [SAMPLE_BITS-1:0]  x_ff;
   logic signed [SAMPLE_BITS-1:0]  rd_ff;
   logic signed [SAMPLE_BITS-1:0]  out_ff;
   logic signed [PW-1:0]           prod_ff;
   logic signed [PW-1:0]           acc_ff;

   logic signed [SAMPLE_BITS-1:0]  delay_mem [MAX_DELAY];

   logic signed [SAMPLE_BITS-1:0]  mul_a;
   logic signed [CW-1:0]           mul_b;
   logic signed [PW-1:0]           mul_p;
   logic [CW-2:0]                  one_minus_damp;
   logic signed [SW-1:0]           lp_sum;
   logic signed [NW-1:0]           lp_shift;
   logic signed [NW-1:0]           wr_sum;
   logic signed [SAMPLE_BITS-1:0]  wr_value;
   logic [LEN_W-1:0]               idx_plus;
   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr;
   logic signed [SAMPLE_BITS-1:0]  mem_wdata;

   // Clamp a wide signed value to the sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [NW-1:0] v);
      logic [3:0] top;
      top = v[NW-1:SAMPLE_BITS-1];
      if (top == 4'b0000 || top == 4'b1111) begin
         sat_smp = v[SAMPLE_BITS-1:0];
      end else if (v[NW-1]) begin
         sat_smp = SMP_MIN;
      end else begin
         sat_smp = SMP_MAX;
      end
   endfunction

   // Configuration writes; the delay length is clamped to one through MAX_DELAY.
   assign len_field = csr_wdata[lfcf_pkg::LEN_FIELD_W-1:0];

   always_comb begin
      len_in  = len_ff;
      damp_in = damp_ff;
      fbg_in  = fbg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lfcf_pkg::CSR_DELAY_LENGTH: begin
               if (len_field == '0) begin
                  len_in = LEN_W'(1);
               end else if (32'(len_field) > 32'(MAX_DELAY)) begin
                  len_in = LEN_W'(MAX_DELAY);
               end else begin
                  len_in = LEN_W'(len_field);
               end
            end
            lfcf_pkg::CSR_DAMPING: begin
               damp_in = csr_wdata[lfcf_pkg::COEF_W-1:0];
            end
            lfcf_pkg::CSR_FEEDBACK_GAIN: begin
               fbg_in = csr_wdata[lfcf_pkg::COEF_W-1:0];
            end
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Shared multiplier: one signed sample operand, one non-negative coefficient.
   assign one_minus_damp = (CW-1)'(1 << FB) - {1'b0, damp_ff};

   always_comb begin
      unique case (cmd.mul_sel)
         lfcf_pkg::MUL_DELAYED: begin
            mul_a = rd_ff;
            mul_b = {1'b0, one_minus_damp};
         end
         lfcf_pkg::MUL_STATE_DAMP: begin
            mul_a = lp_state_ff;
            mul_b = {2'b00, damp_ff};
         end
         lfcf_pkg::MUL_STATE_FB: begin
            mul_a = lp_state_ff;
            mul_b = {2'b00, fbg_ff};
         end
         default: begin
            mul_a = lp_state_ff;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Lowpass update: sum both products, floor by 2^16, saturate.
   assign lp_sum      = {acc_ff[PW-1], acc_ff} + {prod_ff[PW-1], prod_ff};
   assign lp_shift    = lp_sum[SW-1:FB];
   assign lp_state_in = cmd.upd_state ? sat_smp(lp_shift) : lp_state_ff;

   // Written-back value: input plus the floored feedback product, saturated.
   assign wr_sum   = NW'(x_ff) + NW'($signed(prod_ff[PW-1:FB]));
   assign wr_value = sat_smp(wr_sum);

   // Write index advance with wrap at the delay length.
   assign idx_plus = {1'b0, idx_ff} + LEN_W'(1);
   always_comb begin
      idx_in = idx_ff;
      if (cmd.commit) begin
         if (idx_plus >= len_ff) begin
            idx_in = '0;
         end else begin
            idx_in = idx_plus[AW-1:0];
         end
      end
   end

   // Clearing pass address and its end.
   assign clr_addr_in       = cmd.clear_wr ? clr_addr_ff + AW'(1) : clr_addr_ff;
   assign status.clear_done = cmd.clear_wr && (clr_addr_ff == AW'(MAX_DELAY - 1));

   // Single memory write port, shared by the clearing pass and the write-back.
   assign mem_we    = cmd.clear_wr || cmd.commit;
   assign mem_waddr = cmd.clear_wr ? clr_addr_ff : idx_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : wr_value;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         rd_ff <= delay_mem[idx_ff];
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_sample_in;
      end
      if (cmd.mul_sel != lfcf_pkg::MUL_NONE) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_sel == lfcf_pkg::MUL_STATE_DAMP) begin
         acc_ff <= prod_ff;
      end
      if (cmd.commit) begin
         out_ff <= rd_ff;
      end
   end

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_W'(MAX_DELAY);
         damp_ff     <= '0;
         fbg_ff      <= '0;
         idx_ff      <= '0;
         clr_addr_ff <= '0;
         lp_state_ff <= '0;
      end else begin
         len_ff      <= len_in;
         damp_ff     <= damp_in;
         fbg_ff      <= fbg_in;
         idx_ff      <= idx_in;
         clr_addr_ff <= clr_addr_in;
         lp_state_ff <= lp_state_in;
      end
   end

   assign rsp_sample_out = out_ff;

endmodule

// ===== rtl/core/lowpass_feedback_comb_filter.sv =====
// Top level of the lowpass feedback comb filter: sequencer plus datapath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_sample_in  (signed SAMPLE_BITS)
//   rsp      out        rsp_valid/rsp_ready  rsp_sample_out (signed SAMPLE_BITS)
//   csr      in         csr_we               csr_index, csr_wdata (16 bits)
//
// Each accepted sample runs through one delay memory read, then three passes through the
// shared multiplier with a saturating update between them, then the write-back; a new
// sample is taken only after that write-back. After reset a clearing pass writes zero to
// every delay memory entry, during which req_ready stays low; csr writes are taken at
// any time. A stalled rsp beat holds the write-back step until the output register
// frees, so at most one result waits.
module lowpass_feedback_comb_filter #(
   parameter int MAX_DELAY   = lfcf_pkg::MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = lfcf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]    rsp_sample_out,
   input  logic                             csr_we,
   input  logic [lfcf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfcf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lfcf_pkg::cmd_type    cmd;
   lfcf_pkg::status_type status;

   // Step sequencer and result handshake.
   lfcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, state and delay memory.
   lfcf_dp #(
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// ===== tb/lowpass_feedback_comb_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the lowpass feedback comb filter, with a scoreboard class.
module lowpass_feedback_comb_filter_tb;
   import lfcf_pkg::*;

   localparam int MAXD = MAX_DELAY_DEF;
   localparam int SW   = SAMPLE_BITS_DEF;
   localparam longint SMP_MAX = (longint'(1) <<< (SW - 1)) - 1;
   localparam longint SMP_MIN = -SMP_MAX - 1;
   // Register index past the end of the register list; writes to it are dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int MAX_REPORTS = 20;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BEATS = 140;

   typedef logic signed [SW-1:0] sample_t;

   // Predicts the delayed samples and checks the filter output against them.
   class comb_model;
      sample_t             delay_line [MAXD];
      sample_t             lp_state;
      int unsigned         wr_pos;
      int unsigned         len;
      logic [COEF_W-1:0]   damp;
      logic [COEF_W-1:0]   gain;
      sample_t             delayed_q [$];
      int                  errors;
      int                  reports;

      function new();
         foreach (delay_line[i]) delay_line[i] = '0;
         lp_state = '0;
         wr_pos   = 0;
         len      = MAXD;
         damp     = '0;
         gain     = '0;
         errors   = 0;
         reports  = 0;
      endfunction

      function sample_t clamp(longint v);
         if (v > SMP_MAX) return sample_t'(SMP_MAX);
         if (v < SMP_MIN) return sample_t'(SMP_MIN);
         return sample_t'(v);
      endfunction

      function int pending();
         return delayed_q.size();
      endfunction

      // Register writes; an index past the list changes nothing.
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         int unsigned n;
         n = data[LEN_FIELD_W-1:0];
         case (idx)
            CSR_DELAY_LENGTH: begin
               if (n < 1) n = 1;
               if (n > MAXD) n = MAXD;
               len = n;
            end
            CSR_DAMPING:       damp = data[COEF_W-1:0];
            CSR_FEEDBACK_GAIN: gain = data[COEF_W-1:0];
            default: ;
         endcase
      endfunction

      // One accepted input beat: lowpass update, write-back, index step.
      function void take_sample(sample_t x);
         longint y;
         longint acc;
         y = delay_line[wr_pos];
         acc = y * (longint'(65536) - longint'(damp)) + longint'(lp_state) * longint'(damp);
         lp_state = clamp(acc >>> FRAC_BITS);
         acc = longint'(x) + ((longint'(lp_state) * longint'(gain)) >>> FRAC_BITS);
         delay_line[wr_pos] = clamp(acc);
         wr_pos++;
         if (wr_pos >= len) wr_pos = 0;
         delayed_q.push_back(sample_t'(y));
      endfunction

      // One accepted output beat against the oldest prediction.
      function void check_delayed(sample_t act);
         sample_t exp_val;
         if (delayed_q.size() == 0) begin
            errors++;
            if (reports < MAX_REPORTS)
               $display("%0t: unexpected output beat, expected none, got %0d", $time, act);
            reports++;
            return;
         end
         exp_val = delayed_q.pop_front();
         if (act !== exp_val) begin
            errors++;
            if (reports < MAX_REPORTS)
               $display("%0t: sample_out mismatch, expected %0d, got %0d",
                        $time, exp_val, act);
            reports++;
         end
      endfunction

      function void report_leftover();
         if (delayed_q.size() != 0) begin
            errors++;
            $display("%0t: %0d output beats missing, expected next %0d, got none",
                     $time, delayed_q.size(), delayed_q[0]);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   sample_t                 req_sample_in = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   sample_t                 rsp_sample_out;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_DELAY_LENGTH;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   comb_model filt = new();

   lowpass_feedback_comb_filter #(
      .MAX_DELAY   (MAXD),
      .SAMPLE_BITS (SW)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver stalls at random, one decision per cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Observe register writes and both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) filt.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) filt.take_sample(req_sample_in);
         if (rsp_valid && rsp_ready) filt.check_delayed(rsp_sample_out);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Called and returning at a falling edge.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Presents one input beat and holds it until accepted.
   task automatic send_sample(input sample_t s);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Waits until every predicted beat has come out, then lets the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (filt.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic sample_t random_sample();
      case ($urandom_range(0, 9))
         0:       return sample_t'(SMP_MAX);
         1:       return sample_t'(SMP_MIN);
         2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
         default: return sample_t'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] random_coef();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return COEF_W'($urandom_range(60000, 65535));
         default: return COEF_W'($urandom);
      endcase
   endfunction

   // New settings for a random phase; the block is idle here.
   task automatic random_settings();
      logic [CSR_DATA_W-1:0] len_word;
      len_word = CSR_DATA_W'($urandom);
      case ($urandom_range(0, 9))
         0:       len_word[LEN_FIELD_W-1:0] = '0;
         1:       len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'(1);
         2:       len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'(MAXD);
         3:       len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'($urandom_range(MAXD + 1, 4095));
         4:       len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'(MAXD - 1);
         default: len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'($urandom_range(1, 64));
      endcase
      write_csr(CSR_DELAY_LENGTH, len_word);
      write_csr(CSR_DAMPING, random_coef());
      write_csr(CSR_FEEDBACK_GAIN, random_coef());
      if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   initial begin
      int mode;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: the full delay line, so only cleared entries come out.
      send_sample(sample_t'(SMP_MAX));
      send_sample(sample_t'(SMP_MIN));
      drain();

      // Length field of zero with the upper bits set acts as a one-sample delay.
      write_csr(CSR_DELAY_LENGTH, 16'hF000);
      send_sample(sample_t'(SMP_MAX));
      send_sample(sample_t'(SMP_MIN));
      send_sample('0);
      send_sample('1);
      send_sample(sample_t'(1));
      drain();

      // Full damping and full feedback drive the state and write-back into saturation.
      write_csr(CSR_DELAY_LENGTH, 16'd4);
      write_csr(CSR_DAMPING, 16'hFFFF);
      write_csr(CSR_FEEDBACK_GAIN, 16'hFFFF);
      repeat (4) send_sample(sample_t'(SMP_MAX));
      repeat (3) send_sample(sample_t'(SMP_MIN));
      drain();

      // Shorten the line below the write position: that entry is used, then it wraps.
      write_csr(CSR_DELAY_LENGTH, 16'd8);
      write_csr(CSR_DAMPING, 16'h0000);
      write_csr(CSR_FEEDBACK_GAIN, 16'h8000);
      for (int i = 0; i < 6; i++) send_sample(sample_t'(1000 * (i + 1)));
      drain();
      write_csr(CSR_DELAY_LENGTH, 16'd3);
      repeat (3) send_sample(random_sample());
      drain();

      // A length above the maximum is capped, and the spare index is dropped.
      write_csr(CSR_DELAY_LENGTH, 16'h0FFF);
      write_csr(CSR_SPARE, 16'hFFFF);
      send_sample(sample_t'(-12345));
      send_sample(sample_t'(12345));
      drain();

      // Random phases, cycling through the idling modes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = ph % 4;
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         random_settings();
         repeat (PHASE_BEATS) send_sample(random_sample());
         drain();
      end

      repeat (20) @(posedge clock);
      filt.report_leftover();
      if (filt.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
